### src/ffb_pkg.sv
// Shared types and constants for the FIR filter bank.
// No dependencies; the other files, but for ffb_queue, refer to it by scoped names.
package ffb_pkg;

    localparam int MAX_TAPS_DEF     = 256;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int RESULT_CAP       = 8;
    localparam int OUT_DEPTH        = 8;
    localparam int CMD_DEPTH        = 2;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int TAPS_CFG_W  = 9;
    localparam int CHANS_CFG_W = 4;
    localparam int CHAN_W      = 3;
    localparam int RES_W       = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANS = CFG_IDX_W'(1);

    localparam logic [TAPS_CFG_W-1:0]  TAPS_RST  = TAPS_CFG_W'(256);
    localparam logic [CHANS_CFG_W-1:0] CHANS_RST = CHANS_CFG_W'(1);

    localparam logic REQ_LOAD = 1'b0;

    localparam logic signed [RES_W-1:0] RES_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [RES_W-1:0] RES_MIN = 40'sh80_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PUSH,
        OP_RUN
    } op_t;

    typedef struct packed {
        logic               req_type;
        logic [CHAN_W-1:0]  coef_channel;
        logic [7:0]         coef_tap;
        logic signed [15:0] value;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [RES_W-1:0]  result;
        logic                     last;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic [CHAN_W-1:0]  coef_channel;
        logic [7:0]         coef_tap;
        logic signed [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

### src/fir_filter_bank.sv
// Top level of the FIR filter bank: front end, command queue and back end.
// Uses ffb_pkg, ffb_front, ffb_queue and ffb_back.
//
// Input items arrive on push/full/req. A load item (req_type 0) writes one Q1.15
// coefficient at (coef_channel, coef_tap); a sample item (req_type 1) shifts one
// Q1.15 sample into the shared window. Once taps_in_use samples have arrived,
// each sample yields one Q10.30 result per channel in use, channel 0 first, with
// last set on the final one. Results leave on empty/pop/rsp, oldest first.
// Configuration goes in over cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready, and is meant to be written while the bank is idle.
// A load or a sample that gives no result is taken by the back end when idle.
// A sample that runs holds the back end: it takes the sample, then does one
// multiply-accumulate per tap and channel, each reading one coefficient and one
// sample.
// After reset the coefficient table is swept to zero, one entry per cycle,
// 2048 entries at the default size; full stays high during the sweep.
// A two-entry command queue lets the front end take items while the back end
// works. When the receiver stops popping, the eight-entry result queue fills
// and the accumulator holds at the start of the next channel.
module fir_filter_bank #(
    parameter  int MAX_TAPS     = ffb_pkg::MAX_TAPS_DEF,
    parameter  int MAX_CHANNELS = ffb_pkg::MAX_CHANNELS_DEF,
    localparam int CNT_W        = $clog2(MAX_TAPS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  ffb_pkg::req_t                  req,
    output logic                           empty,
    input  logic                           pop,
    output ffb_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffb_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                            cmd_push;
    logic                            cmd_full;
    logic                            cmd_pop;
    logic                            cmd_empty;
    ffb_pkg::cmd_t                   cmd_in;
    ffb_pkg::cmd_t                   cmd_out;
    ffb_pkg::back_status_t           status;
    logic [CNT_W-1:0]                taps;
    logic [ffb_pkg::CHANS_CFG_W-1:0] chans;

    ffb_front #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full),
        .status    (status),
        .taps      (taps),
        .chans     (chans)
    );

    ffb_queue #(
        .T     (ffb_pkg::cmd_t),
        .DEPTH (ffb_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .rd    (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    ffb_back #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .taps      (taps),
        .chans     (chans),
        .status    (status),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

### src/ffb_queue.sv
// Small first-in first-out queue of any packed type.
// Uses no package items; instantiated between front and back and for results.
module ffb_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  T     din,
    output logic full,
    input  logic rd,
    output T     dout,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               q_mem [DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wp_next;
    logic [PW-1:0]  rp_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = q_mem[rp_reg];

    assign wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
    assign rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_mem[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_next;
            end
            if (rd)
            begin
                rp_reg <= rp_next;
            end
            count_reg <= count_reg + CW'(wr) - CW'(rd);
        end
    end

endmodule

### src/ffb_front.sv
// Front end: takes items, holds the configuration registers and the fill count,
// and tags each item as a load, a quiet sample or a sample that runs. Uses ffb_pkg.
module ffb_front #(
    parameter  int MAX_TAPS     = ffb_pkg::MAX_TAPS_DEF,
    parameter  int MAX_CHANNELS = ffb_pkg::MAX_CHANNELS_DEF,
    localparam int CNT_W        = $clog2(MAX_TAPS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  ffb_pkg::req_t                     req,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              cmd_push,
    output ffb_pkg::cmd_t                     cmd,
    input  logic                              cmd_full,
    input  ffb_pkg::back_status_t             status,
    output logic [CNT_W-1:0]                  taps,
    output logic [ffb_pkg::CHANS_CFG_W-1:0]   chans
);

    localparam int CH_LIM = (MAX_CHANNELS < ffb_pkg::RESULT_CAP) ?
                            MAX_CHANNELS : ffb_pkg::RESULT_CAP;

    logic [ffb_pkg::TAPS_CFG_W-1:0]  taps_cfg_reg;
    logic [ffb_pkg::CHANS_CFG_W-1:0] chans_cfg_reg;
    logic [CNT_W-1:0]                fill_reg;
    logic [CNT_W-1:0]                fill_next;
    logic                            accept;
    logic                            is_sample;

    assign cfg_ready = 1'b1;

    // Clamp the registers to what the bank can hold
    always_comb
    begin
        if (taps_cfg_reg == '0)
        begin
            taps = CNT_W'(1);
        end
        else if (32'(taps_cfg_reg) > 32'(MAX_TAPS))
        begin
            taps = CNT_W'(MAX_TAPS);
        end
        else
        begin
            taps = CNT_W'(taps_cfg_reg);
        end

        if (chans_cfg_reg == '0)
        begin
            chans = ffb_pkg::CHANS_CFG_W'(1);
        end
        else if (32'(chans_cfg_reg) > 32'(CH_LIM))
        begin
            chans = ffb_pkg::CHANS_CFG_W'(CH_LIM);
        end
        else
        begin
            chans = chans_cfg_reg;
        end
    end

    // Hold off new items while the back end sweeps the coefficient table
    assign full      = cmd_full || status.clearing;
    assign accept    = push && !full;
    assign is_sample = (req.req_type != ffb_pkg::REQ_LOAD);
    assign fill_next = (fill_reg < CNT_W'(MAX_TAPS)) ? fill_reg + CNT_W'(1) : fill_reg;

    assign cmd_push = accept;

    always_comb
    begin
        cmd.coef_channel = req.coef_channel;
        cmd.coef_tap     = req.coef_tap;
        cmd.value        = req.value;
        if (!is_sample)
        begin
            cmd.op = ffb_pkg::OP_LOAD;
        end
        else if (fill_next >= taps)
        begin
            cmd.op = ffb_pkg::OP_RUN;
        end
        else
        begin
            cmd.op = ffb_pkg::OP_PUSH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_cfg_reg  <= ffb_pkg::TAPS_RST;
            chans_cfg_reg <= ffb_pkg::CHANS_RST;
            fill_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ffb_pkg::CFG_TAPS:  taps_cfg_reg  <= cfg_data;
                    ffb_pkg::CFG_CHANS: chans_cfg_reg <= cfg_data[ffb_pkg::CHANS_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (accept && is_sample)
            begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

### src/ffb_back.sv
// Back end: coefficient table, circular sample window, shared multiply-accumulate
// and the result queue. Uses ffb_pkg and ffb_queue.
module ffb_back #(
    parameter  int MAX_TAPS     = ffb_pkg::MAX_TAPS_DEF,
    parameter  int MAX_CHANNELS = ffb_pkg::MAX_CHANNELS_DEF,
    localparam int CNT_W        = $clog2(MAX_TAPS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_empty,
    output logic                              cmd_pop,
    input  ffb_pkg::cmd_t                     cmd,
    input  logic [CNT_W-1:0]                  taps,
    input  logic [ffb_pkg::CHANS_CFG_W-1:0]   chans,
    output ffb_pkg::back_status_t             status,
    output logic                              empty,
    input  logic                              pop,
    output ffb_pkg::rsp_t                     rsp
);

    localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CA_W  = CH_W + TAP_W;
    localparam int ACC_W = (33 + TAP_W > ffb_pkg::RES_W) ? 33 + TAP_W : ffb_pkg::RES_W;
    localparam int CRD_W = $clog2(ffb_pkg::OUT_DEPTH + 1);
    localparam int B_W   = CNT_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(ffb_pkg::RES_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(ffb_pkg::RES_MIN);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE
    } state_t;

    typedef struct packed {
        logic                       first;
        logic                       last_tap;
        logic                       last_ch;
        logic [ffb_pkg::CHAN_W-1:0] chan;
    } tag_t;

    logic signed [15:0] coef_mem [2**CA_W];
    logic signed [15:0] win_mem  [MAX_TAPS];

    state_t                     state_reg;
    logic [CA_W-1:0]            clr_addr_reg;
    logic [TAP_W-1:0]           wp_reg;
    logic [TAP_W-1:0]           base_reg;
    logic [TAP_W-1:0]           sa_reg;
    logic [TAP_W-1:0]           tap_reg;
    logic [ffb_pkg::CHAN_W-1:0] ch_reg;
    logic [CRD_W-1:0]           credit_reg;

    logic                       s1_valid_reg;
    tag_t                       s1_tag_reg;
    logic signed [15:0]         coef_q_reg;
    logic signed [15:0]         smp_q_reg;
    logic                       s2_valid_reg;
    tag_t                       s2_tag_reg;
    logic signed [31:0]         prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                       load_we;
    logic                       smp_we;
    logic [TAP_W-1:0]           wp_inc;
    logic [TAP_W-1:0]           sa_inc;
    logic [B_W-1:0]             base_sum;
    logic [B_W-1:0]             base_mod;
    logic [TAP_W-1:0]           base;
    logic                       tap_last;
    logic                       ch_last;
    logic                       issue;
    logic                       take;
    logic signed [ACC_W-1:0]    sum;
    logic                       oq_push;
    logic                       oq_full;
    logic                       oq_pop;
    ffb_pkg::rsp_t              oq_din;

    assign status.clearing = (state_reg == ST_CLEAR);

    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;
    assign load_we = cmd_pop && (cmd.op == ffb_pkg::OP_LOAD)
                     && (32'(cmd.coef_channel) < 32'(MAX_CHANNELS))
                     && (32'(cmd.coef_tap) < 32'(MAX_TAPS));
    assign smp_we  = cmd_pop && (cmd.op != ffb_pkg::OP_LOAD);

    assign wp_inc = (wp_reg == TAP_W'(MAX_TAPS - 1)) ? '0 : wp_reg + TAP_W'(1);
    assign sa_inc = (sa_reg == TAP_W'(MAX_TAPS - 1)) ? '0 : sa_reg + TAP_W'(1);

    // Oldest sample of the window sits taps-1 places behind the newest one
    assign base_sum = B_W'(wp_reg) + B_W'(MAX_TAPS) - B_W'(taps) + B_W'(1);
    assign base_mod = (base_sum >= B_W'(MAX_TAPS)) ? base_sum - B_W'(MAX_TAPS) : base_sum;
    assign base     = TAP_W'(base_mod);

    assign tap_last = (CNT_W'(tap_reg) == taps - CNT_W'(1));
    assign ch_last  = ({1'b0, ch_reg} == chans - ffb_pkg::CHANS_CFG_W'(1));

    // Start a channel only with a free slot reserved in the result queue
    assign issue = (state_reg == ST_ISSUE) && ((tap_reg != '0) || (credit_reg != '0));
    assign take  = issue && (tap_reg == '0);

    assign sum = s2_tag_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        oq_din.channel = s2_tag_reg.chan;
        oq_din.last    = s2_tag_reg.last_ch;
        if (sum > SAT_HI)
        begin
            oq_din.result = ffb_pkg::RES_MAX;
        end
        else if (sum < SAT_LO)
        begin
            oq_din.result = ffb_pkg::RES_MIN;
        end
        else
        begin
            oq_din.result = sum[ffb_pkg::RES_W-1:0];
        end
    end

    assign oq_push = s2_valid_reg && s2_tag_reg.last_tap && !oq_full;
    assign oq_pop  = pop && !empty;

    // Coefficient table: clearing sweep, loads and one read per cycle while issuing
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            coef_mem[clr_addr_reg] <= '0;
        end
        else if (load_we)
        begin
            coef_mem[{CH_W'(cmd.coef_channel), TAP_W'(cmd.coef_tap)}] <= cmd.value;
        end
        if (issue)
        begin
            coef_q_reg <= coef_mem[{CH_W'(ch_reg), tap_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            win_mem[wp_reg] <= cmd.value;
        end
        if (issue)
        begin
            smp_q_reg <= win_mem[sa_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= '{first:    (tap_reg == '0),
                        last_tap: tap_last,
                        last_ch:  ch_last,
                        chan:     ch_reg};
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= coef_q_reg * smp_q_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            base_reg     <= '0;
            sa_reg       <= '0;
            tap_reg      <= '0;
            ch_reg       <= '0;
            credit_reg   <= CRD_W'(ffb_pkg::OUT_DEPTH);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            credit_reg   <= credit_reg - CRD_W'(take) + CRD_W'(oq_pop);

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + CA_W'(1);
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (smp_we)
                    begin
                        wp_reg <= wp_inc;
                    end
                    if (cmd_pop && (cmd.op == ffb_pkg::OP_RUN))
                    begin
                        base_reg  <= base;
                        sa_reg    <= base;
                        tap_reg   <= '0;
                        ch_reg    <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (issue)
                    begin
                        if (tap_last)
                        begin
                            tap_reg <= '0;
                            sa_reg  <= base_reg;
                            ch_reg  <= ch_reg + ffb_pkg::CHAN_W'(1);
                            if (ch_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            tap_reg <= tap_reg + TAP_W'(1);
                            sa_reg  <= sa_inc;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ffb_queue #(
        .T     (ffb_pkg::rsp_t),
        .DEPTH (ffb_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (oq_push),
        .din   (oq_din),
        .full  (oq_full),
        .rd    (oq_pop),
        .dout  (rsp),
        .empty (empty)
    );

endmodule

### src/ffb_checker.sv
// Port-level checks for the FIR filter bank, bound to the top level.
// Uses ffb_pkg for the result item type.
module ffb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input ffb_pkg::rsp_t rsp
);

    // In reset: no results, and no items taken
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (empty && full))
        else $error("result or input space visible during reset");

    // The table sweep holds input closed right after reset
    a_sweep_closed: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> full)
        else $error("input open while the coefficient table is swept");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("waiting result changed or dropped");

    // At most eight channels, so channel seven always closes a sample
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.last) |-> (rsp.channel != 3'd7))
        else $error("channel seven result not flagged as last");

endmodule

bind fir_filter_bank ffb_checker u_ffb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);
